>>> src/drrc_pkg.sv
// shared types, constants and the power-of-ten table for the decimal rescale block
// no dependencies
package drrc_pkg;

    localparam int unsigned VAL_W          = 61;
    localparam int unsigned DIG_W          = 5;
    localparam int unsigned VALUE_DIGITS   = 18;
    localparam int unsigned MAX_DIGITS_DEF = 18;

    typedef logic [VAL_W-1:0] mag_t;
    typedef logic [DIG_W-1:0] dig_t;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH = 2'd0,
        REG_SRC_SCALE = 2'd1,
        REG_TGT_WIDTH = 2'd2,
        REG_TGT_SCALE = 2'd3
    } cfg_reg_t;

    // one item moving along the row of divide/multiply cells
    typedef struct packed {
        logic vld;
        logic last;
        logic neg;
        logic up;
        logic pre_bad;
        logic chk;
        mag_t mag;
        mag_t lim;
        mag_t fac;
        mag_t d1;
        mag_t d2;
        mag_t r1;
        mag_t r2;
        mag_t q1;
        mag_t prod;
    } cell_t;

    typedef struct packed {
        logic vld;
        logic last;
        logic neg;
        logic up;
        logic pre_bad;
        logic chk;
        mag_t qr;
        mag_t rin;
        mag_t lim;
    } fin_t;

    function automatic mag_t pow10(input dig_t n);
        mag_t p;
        case (n)
            5'd0:    p = 61'd1;
            5'd1:    p = 61'd10;
            5'd2:    p = 61'd100;
            5'd3:    p = 61'd1000;
            5'd4:    p = 61'd10000;
            5'd5:    p = 61'd100000;
            5'd6:    p = 61'd1000000;
            5'd7:    p = 61'd10000000;
            5'd8:    p = 61'd100000000;
            5'd9:    p = 61'd1000000000;
            5'd10:   p = 61'd10000000000;
            5'd11:   p = 61'd100000000000;
            5'd12:   p = 61'd1000000000000;
            5'd13:   p = 61'd10000000000000;
            5'd14:   p = 61'd100000000000000;
            5'd15:   p = 61'd1000000000000000;
            5'd16:   p = 61'd10000000000000000;
            5'd17:   p = 61'd100000000000000000;
            default: p = 61'd1000000000000000000;
        endcase
        return p;
    endfunction

endpackage

>>> src/drrc_cell.sv
// one cell of the row: a restoring-divide bit step on two remainders and
// a shift-add multiply step; depends on drrc_pkg
module drrc_cell
    import drrc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cell_t din,
    output cell_t dout
);

    cell_t data_reg;
    cell_t data_next;
    mag_t  t1;
    mag_t  t2;
    logic  qb;

    always_comb
    begin
        data_next = din;
        t1 = {din.r1[VAL_W-2:0], din.mag[VAL_W-1-IDX]};
        t2 = {din.r2[VAL_W-2:0], din.mag[VAL_W-1-IDX]};
        qb = (t1 >= din.d1);
        data_next.r1 = qb ? (t1 - din.d1) : t1;
        data_next.q1 = {din.q1[VAL_W-2:0], qb};
        data_next.r2 = (t2 >= din.d2) ? (t2 - din.d2) : t2;
        data_next.prod = din.prod + (din.fac[IDX] ? (din.mag << IDX) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else if (en)
            data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

>>> src/decimal_rescale_round_check_top.sv
// decimal rescale top level: config registers, front stage, cell row, round and range stages
// depends on drrc_pkg and drrc_cell
// One value is accepted per cycle whenever the pipeline advances; it passes through one front stage, a
// row of 61 cells (one per magnitude bit, each doing one restoring-divide step by the scale
// factor and one shift-add multiply step), a rounding stage and the output register. The whole
// pipeline advances whenever the output register is empty or its transfer completes. Scaling
// up multiplies by 10^diff; scaling down rounds half away from zero. A value that does not fit
// the target gives zero with out_of_range set. Register values above MAX_DIGITS act as
// MAX_DIGITS. Write configuration only while the pipeline is empty.
module decimal_rescale_round_check_top
    import drrc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [DIG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [VAL_W-1:0] value_in,
    input  logic                    last_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] value_out,
    output logic                    out_of_range,
    output logic                    last_out
);

    localparam int NCELL = VAL_W;
    localparam dig_t MAXD = dig_t'(MAX_DIGITS);

    dig_t src_width_reg, src_width_next;
    dig_t src_scale_reg, src_scale_next;
    dig_t tgt_width_reg, tgt_width_next;
    dig_t tgt_scale_reg, tgt_scale_next;

    logic en;
    cell_t front_reg, front_next;
    cell_t chain [NCELL+1];
    fin_t fin_reg, fin_next;
    logic out_valid_reg, out_valid_next;
    mag_t val_reg, val_next;
    logic oor_reg, oor_next;
    logic last_reg, last_next;

    dig_t sw, ss, tw, ts, dup, ddn;
    logic [DIG_W:0] reach;

    assign cfg_ready = 1'b1;
    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        src_width_next = src_width_reg;
        src_scale_next = src_scale_reg;
        tgt_width_next = tgt_width_reg;
        tgt_scale_next = tgt_scale_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_WIDTH: src_width_next = cfg_data;
                REG_SRC_SCALE: src_scale_next = cfg_data;
                REG_TGT_WIDTH: tgt_width_next = cfg_data;
                REG_TGT_SCALE: tgt_scale_next = cfg_data;
                default:       src_width_next = src_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg <= dig_t'(18);
            src_scale_reg <= '0;
            tgt_width_reg <= dig_t'(18);
            tgt_scale_reg <= '0;
        end
        else
        begin
            src_width_reg <= src_width_next;
            src_scale_reg <= src_scale_next;
            tgt_width_reg <= tgt_width_next;
            tgt_scale_reg <= tgt_scale_next;
        end
    end

    // front stage: saturate, magnitude, factors, the scale-up range test and the scale-down limit
    always_comb
    begin
        sw = (src_width_reg > MAXD) ? MAXD : src_width_reg;
        ss = (src_scale_reg > MAXD) ? MAXD : src_scale_reg;
        tw = (tgt_width_reg > MAXD) ? MAXD : tgt_width_reg;
        ts = (tgt_scale_reg > MAXD) ? MAXD : tgt_scale_reg;
        dup = ts - ss;
        ddn = ss - ts;
        reach = {1'b0, tw} + {1'b0, ddn};
        front_next = '0;
        front_next.vld = in_valid;
        front_next.last = last_in;
        front_next.neg = value_in[VAL_W-1];
        front_next.mag = value_in[VAL_W-1] ? mag_t'(~value_in + 1'b1) : mag_t'(value_in);
        front_next.up = (ts >= ss);
        if (ts >= ss)
        begin
            front_next.fac = pow10(dup);
            front_next.d1 = mag_t'(1);
            front_next.d2 = mag_t'(1);
            front_next.pre_bad =
                ((dup <= tw) && (sw >= tw - dup) && (front_next.mag >= pow10(tw - dup)))
                || (front_next.mag >= pow10(dig_t'(VALUE_DIGITS) - dup));
        end
        else
        begin
            front_next.d1 = pow10(ddn);
            front_next.d2 = pow10(ss);
            front_next.chk = ({1'b0, sw} >= reach);
            front_next.lim = pow10(reach[DIG_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_reg <= '0;
        else if (en)
            front_reg <= front_next;
    end

    assign chain[0] = front_reg;

    genvar k;
    generate
        for (k = 0; k < NCELL; k++)
        begin : g_cell
            drrc_cell #(.IDX(k)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (en),
                .din  (chain[k]),
                .dout (chain[k+1])
            );
        end
    endgenerate

    // rounding and the scale-down range sum
    always_comb
    begin
        fin_next.vld = chain[NCELL].vld;
        fin_next.last = chain[NCELL].last;
        fin_next.neg = chain[NCELL].neg;
        fin_next.up = chain[NCELL].up;
        fin_next.pre_bad = chain[NCELL].pre_bad;
        fin_next.chk = chain[NCELL].chk;
        fin_next.lim = chain[NCELL].lim;
        fin_next.qr = chain[NCELL].up ? chain[NCELL].prod
            : chain[NCELL].q1 + mag_t'(chain[NCELL].r1 >= (chain[NCELL].d1 >> 1));
        fin_next.rin = chain[NCELL].mag
            + ((chain[NCELL].r2 >= (chain[NCELL].d2 >> 1)) ? chain[NCELL].d2 : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= '0;
        else if (en)
            fin_reg <= fin_next;
    end

    always_comb
    begin
        oor_next = fin_reg.up ? fin_reg.pre_bad : (fin_reg.chk && (fin_reg.rin >= fin_reg.lim));
        val_next = oor_next ? '0 : (fin_reg.neg ? mag_t'(~fin_reg.qr + 1'b1) : fin_reg.qr);
        last_next = fin_reg.last;
        out_valid_next = en ? fin_reg.vld : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            oor_reg <= oor_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = signed'(val_reg);
    assign out_of_range = oor_reg;
    assign last_out = last_reg;

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (value_out == '0))
        else $error("flagged result not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value_out) && $stable(last_out)))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready out of step with output stage");

endmodule

>>> sim/decimal_rescale_round_check_top_test.sv
// testbench for decimal_rescale_round_check_top: directed and random values over many width/scale
// settings, checked against a rescale-and-round predictor held in a small scoreboard class
// depends on drrc_pkg and the decimal rescale RTL
module decimal_rescale_round_check_top_test;
    import drrc_pkg::*;

    localparam longint VALUE_MAX = 64'sd999999999999999999;

    class rescale_scoreboard;
        int unsigned src_w = 18, src_s = 0, tgt_w = 18, tgt_s = 0;
        longint      want_value[$];
        bit          want_oor[$];
        bit          want_last[$];
        int          errors;
        int          checked;
        int          flagged;

        function longint ten_to(int unsigned n);
            longint p;
            p = 1;
            if (n > 18) n = 18;
            repeat (n) p = p * 10;
            return p;
        endfunction

        function int unsigned clip(int unsigned x);
            return x > 18 ? 18 : x;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [DIG_W-1:0] d);
            case (idx)
                REG_SRC_WIDTH: src_w = d;
                REG_SRC_SCALE: src_s = d;
                REG_TGT_WIDTH: tgt_w = d;
                REG_TGT_SCALE: tgt_s = d;
                default:       src_w = src_w;
            endcase
        endfunction

        function void note_input(longint v, bit last);
            int unsigned sw, ss, tw, ts, diff, reach;
            longint r, mag, lim, half, dv, rem, rin, q;
            bit bad;
            sw = clip(src_w);
            ss = clip(src_s);
            tw = clip(tgt_w);
            ts = clip(tgt_s);
            r = 0;
            bad = 0;
            if (ts >= ss) begin
                diff = ts - ss;
                mag = v < 0 ? -v : v;
                if (diff <= tw && sw >= tw - diff) begin
                    lim = ten_to(tw - diff);
                    if (v >= lim || v <= -lim) bad = 1;
                end
                if (!bad && mag > VALUE_MAX / ten_to(diff)) bad = 1;
                if (!bad) r = v * ten_to(diff);
            end else begin
                diff = ss - ts;
                reach = tw + diff;
                half = ten_to(diff) / 2;
                if (sw >= reach) begin
                    dv = ten_to(ss);
                    rem = v % dv;
                    rin = v;
                    if (rin < 0) begin
                        rin = -rin;
                        rem = -rem;
                    end
                    if (rem >= dv / 2) rin = rin + dv;
                    lim = ten_to(reach);
                    if (!(rin < lim && rin > -lim)) bad = 1;
                end
                if (!bad) begin
                    q = v / half;
                    q = q < 0 ? q - 1 : q + 1;
                    r = q / 2;
                    if (r > VALUE_MAX || r < -VALUE_MAX) bad = 1;
                end
            end
            if (bad) r = 0;
            want_value.push_back(r);
            want_oor.push_back(bad);
            want_last.push_back(last);
        endfunction

        function void check_result(logic signed [VAL_W-1:0] val, logic oor, logic last);
            logic signed [VAL_W-1:0] ev;
            checked++;
            if (want_value.size() == 0) begin
                $error("result with nothing expected: value_out %0d", val);
                errors++;
                return;
            end
            ev = VAL_W'(want_value.pop_front());
            if (val !== ev) begin
                $error("value_out expected %0d actual %0d", ev, val);
                errors++;
            end
            if (oor !== want_oor[0]) begin
                $error("out_of_range expected %0d actual %0d", want_oor[0], oor);
                errors++;
            end
            if (last !== want_last[0]) begin
                $error("last_out expected %0d actual %0d", want_last[0], last);
                errors++;
            end
            if (want_oor[0]) flagged++;
            void'(want_oor.pop_front());
            void'(want_last.pop_front());
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [DIG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [VAL_W-1:0] value_in;
    logic                    last_in;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [VAL_W-1:0] value_out;
    logic                    out_of_range;
    logic                    last_out;

    rescale_scoreboard rescale_sb;
    bit                steady;
    int                phases_run;

    decimal_rescale_round_check_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .value_in(value_in), .last_in(last_in),
        .out_valid(out_valid), .out_ready(out_ready), .value_out(value_out),
        .out_of_range(out_of_range), .last_out(last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // receiver side
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(99) >= 10);
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            rescale_sb.check_result(value_out, out_of_range, last_out);
    end

    task automatic write_reg(cfg_reg_t idx, logic [DIG_W-1:0] d);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        took = 0;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        rescale_sb.write_reg(idx, d);
    endtask

    task automatic load_setting(logic [DIG_W-1:0] sw, logic [DIG_W-1:0] ss,
                                logic [DIG_W-1:0] tw, logic [DIG_W-1:0] ts);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_SCALE, ss);
        write_reg(REG_TGT_WIDTH, tw);
        write_reg(REG_TGT_SCALE, ts);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_value(longint v, bit last);
        bit took;
        if (!steady && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value_in <= v[VAL_W-1:0];
        last_in  <= last;
        took = 0;
        while (!took)
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        rescale_sb.note_input(v, last);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (rescale_sb.want_value.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic longint random_value();
        longint m, p, c;
        int unsigned d;
        c = $urandom_range(99);
        d = $urandom_range(0, 18);
        p = rescale_sb.ten_to(d);
        m = {$urandom, $urandom};
        if (m < 0) m = -m;
        if (c < 15)
            m = p - $urandom_range(0, 1);                      // at or just below a power of ten
        else if (c < 35)
            m = (m % (p / 10 + 1)) * 10 + 5 * ($urandom_range(1) ? p / 10 : 1);
        else
            m = m % p;
        if (m > VALUE_MAX) m = VALUE_MAX;
        return $urandom_range(1) ? -m : m;
    endfunction

    initial
    begin
        longint edge_vals[$];
        int unsigned sw, ss, tw, ts;
        rescale_sb = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SRC_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        value_in  <= '0;
        last_in   <= 1'b0;
        steady    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset setting, then at a scaled-down, a saturated and a scale-up setting
        edge_vals = '{0, 1, -1, VALUE_MAX, -VALUE_MAX, 64'sd576460752303423488,
                      -64'sd576460752303423488, 64'sd100000000000000000, -5, 5, 15, -15, 49, -50};
        foreach (edge_vals[i]) send_value(edge_vals[i], i[0]);
        drain();
        load_setting(18, 2, 16, 0);
        foreach (edge_vals[i]) send_value(edge_vals[i], ~i[0]);
        drain();
        load_setting(31, 31, 31, 31);
        for (int i = 0; i < 4; i++) send_value(edge_vals[i], 1'b1);
        drain();
        load_setting(18, 0, 5, 17);                            // scale-up wrap of the range test
        for (int i = 0; i < 6; i++) send_value(edge_vals[i], 1'b0);
        drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0: begin sw = 1;  ss = 0;  tw = 1;  ts = 0;  end
                1: begin sw = 18; ss = 18; tw = 1;  ts = 0;  end
                2: begin sw = 1;  ss = 1;  tw = 18; ts = 18; end
                3: begin sw = 18; ss = 0;  tw = 18; ts = 18; end
                4: begin sw = 18; ss = 17; tw = 18; ts = 0;  end
                5: begin sw = 25; ss = 20; tw = 3;  ts = 1;  end
                default:
                begin
                    sw = $urandom_range(1, 18);
                    tw = $urandom_range(1, 18);
                    ss = $urandom_range(0, sw);
                    ts = $urandom_range(0, tw);
                end
            endcase
            load_setting(DIG_W'(sw), DIG_W'(ss), DIG_W'(tw), DIG_W'(ts));
            steady = (ph == 7);
            for (int i = 0; i < 75; i++) send_value(random_value(), $urandom_range(1));
            drain();
            phases_run++;
        end

        in_valid <= 1'b0;
        drain();
        repeat (70) @(posedge clk);
        $display("covered %0d results (%0d out of range) over %0d register settings",
                 rescale_sb.checked, rescale_sb.flagged, phases_run + 4);
        if (rescale_sb.errors == 0 && rescale_sb.want_value.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
src/drrc_pkg.sv
src/drrc_cell.sv
src/decimal_rescale_round_check_top.sv
sim/decimal_rescale_round_check_top_test.sv
